/* hdl/sha_pkg.sv */
// Shared types, constants and round functions of the SHA-256 byte-stream hasher.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

    // One input item as it travels through the queue.
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       end_of_message;
    } item_t;

    // Head of the item queue as seen by the back part.
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    // Back part sequencer states.
    typedef enum logic [2:0] {
        ST_FETCH,
        ST_PAD,
        ST_ROUND,
        ST_ADD
    } back_state_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    localparam logic [7:0][31:0] INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [63:0][31:0] ROUND_K = {
        32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
        32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
        32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
        32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
        32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
        32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
        32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
        32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
        32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
        32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
        32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
        32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
        32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
        32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
        32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
        32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage
`default_nettype wire

/* hdl/sha_in_if.sv */
// Input channel: one message byte with its flags per transfer.
`timescale 1ns / 1ps
`default_nettype none
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output msg_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink (input valid, input msg_byte, input byte_present,
                  input end_of_message, output ready);
endinterface
`default_nettype wire

/* hdl/sha_out_if.sv */
// Output channel: the eight digest words of one message per transfer.
`timescale 1ns / 1ps
`default_nettype none
interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_w0;
    logic [31:0] digest_w1;
    logic [31:0] digest_w2;
    logic [31:0] digest_w3;
    logic [31:0] digest_w4;
    logic [31:0] digest_w5;
    logic [31:0] digest_w6;
    logic [31:0] digest_w7;

    modport source (output valid, output digest_w0, output digest_w1, output digest_w2,
                    output digest_w3, output digest_w4, output digest_w5,
                    output digest_w6, output digest_w7, input ready);
    modport sink (input valid, input digest_w0, input digest_w1, input digest_w2,
                  input digest_w3, input digest_w4, input digest_w5,
                  input digest_w6, input digest_w7, output ready);
endinterface
`default_nettype wire

/* hdl/sha256_byte_stream_hasher.sv */
// Top level of the SHA-256 byte-stream hasher.
// Computes the SHA-256 digest of a message fed one byte per transfer. The back part
// takes one queued byte per cycle while it is not compressing or padding, and runs
// every full 64-byte block through 64 rounds of one shared round unit plus the
// chaining add. The item that ends a message adds padding at one byte per cycle and
// one or two further compressions, depending on where the pad byte lands.
// A two-entry queue in front lets bytes arrive while a block is compressed;
// the digest sits in an output register so the next message can start meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module sha256_byte_stream_hasher (
    input  wire logic clk,
    input  wire logic rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);
    import sha_pkg::*;

    queue_head_t head;
    logic        pop;

    sha_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .head  (head),
        .pop   (pop)
    );

    sha_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .out_ch (out_ch)
    );

    // The back part never takes an item from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head.valid)
        else $error("item taken from empty queue");

    // A stalled input side means the queue holds items.
    assert property (@(posedge clk) disable iff (!rst_n) !in_ch.ready |-> head.valid)
        else $error("input stalled with empty queue");

    // A digest waiting for transfer stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
                     out_ch.valid && !out_ch.ready |=> out_ch.valid)
        else $error("digest dropped before transfer");
endmodule
`default_nettype wire

/* hdl/sha_front.sv */
// Front part: accepts items, drops those with no effect, and queues the rest.
`timescale 1ns / 1ps
`default_nettype none
module sha_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    sha_in_if.sink                  in_ch,
    output sha_pkg::queue_head_t    head,
    input  wire logic               pop
);
    import sha_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       do_pop;

    // An absent byte that does not end the message changes nothing.
    assign in_ch.ready = (count_reg != 2'd2);
    assign push   = in_ch.valid && in_ch.ready && (in_ch.byte_present || in_ch.end_of_message);
    assign do_pop = pop && (count_reg != 2'd0);

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = entry_reg[rd_ptr_reg];

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= '{msg_byte: in_ch.msg_byte,
                                       byte_present: in_ch.byte_present,
                                       end_of_message: in_ch.end_of_message};
        end
    end
endmodule
`default_nettype wire

/* hdl/sha_back.sv */
// Back part: byte intake, padding, 64-round compression and digest register.
`timescale 1ns / 1ps
`default_nettype none
module sha_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sha_pkg::queue_head_t head,
    output logic                    pop,
    sha_out_if.source               out_ch
);
    import sha_pkg::*;

    back_state_t      state_reg, state_next;
    logic [15:0][31:0] w_reg, w_next;
    logic [7:0][31:0] v_reg, v_next;
    logic [7:0][31:0] h_reg, h_next;
    logic [7:0][31:0] dig_reg, dig_next;
    logic [7:0][31:0] sums;
    logic             dig_valid_reg, dig_valid_next;
    logic [63:0]      bits_reg, bits_next;
    logic [5:0]       pos_reg, pos_next;
    logic [5:0]       rnd_reg, rnd_next;
    logic             padding_reg, padding_next;
    logic             first_reg, first_next;
    logic             len_ok_reg, len_ok_next;
    logic             final_reg, final_next;
    logic             shift_en;
    logic [7:0]       shift_byte;
    logic [7:0]       len_byte;
    logic [31:0]      w_new, t1, t2;

    // Length byte for buffer positions 56 to 63, most significant first.
    assign len_byte = bits_reg[{3'd7 - pos_reg[2:0], 3'b000} +: 8];

    // Round datapath: the window holds W[t] to W[t+15], W[t] on top.
    assign w_new = small_sigma1(w_reg[1]) + w_reg[6] + small_sigma0(w_reg[14]) + w_reg[15];
    assign t1 = v_reg[7] + big_sigma1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + ROUND_K[rnd_reg] + w_reg[15];
    assign t2 = big_sigma0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            sums[i] = h_reg[i] + v_reg[i];
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        w_next         = w_reg;
        v_next         = v_reg;
        h_next         = h_reg;
        dig_next       = dig_reg;
        dig_valid_next = dig_valid_reg && !out_ch.ready;
        bits_next      = bits_reg;
        pos_next       = pos_reg;
        rnd_next       = rnd_reg;
        padding_next   = padding_reg;
        first_next     = first_reg;
        len_ok_next    = len_ok_reg;
        final_next     = final_reg;
        pop            = 1'b0;
        shift_en       = 1'b0;
        shift_byte     = head.item.msg_byte;

        unique case (state_reg)
            ST_FETCH:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.item.end_of_message)
                    begin
                        padding_next = 1'b1;
                        first_next   = 1'b1;
                        len_ok_next  = 1'b0;
                        final_next   = 1'b0;
                        state_next   = ST_PAD;
                    end
                    if (head.item.byte_present)
                    begin
                        shift_en  = 1'b1;
                        bits_next = bits_reg + 64'd8;
                        pos_next  = pos_reg + 6'd1;
                        if (pos_reg == 6'd63)
                        begin
                            v_next     = h_reg;
                            rnd_next   = 6'd0;
                            state_next = ST_ROUND;
                        end
                    end
                end
            end
            ST_PAD:
            begin
                shift_en   = 1'b1;
                first_next = 1'b0;
                pos_next   = pos_reg + 6'd1;
                if (first_reg)
                begin
                    shift_byte = PAD_BYTE;
                    if (pos_reg < LEN_POS)
                    begin
                        len_ok_next = 1'b1;
                    end
                end
                else if (len_ok_reg && pos_reg >= LEN_POS)
                begin
                    shift_byte = len_byte;
                end
                else
                begin
                    shift_byte = 8'h00;
                end
                if (pos_reg == 6'd63)
                begin
                    final_next = len_ok_reg && !first_reg;
                    v_next     = h_reg;
                    rnd_next   = 6'd0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                w_next   = {w_reg[14:0], w_new};
                v_next   = {v_reg[6:4], v_reg[3] + t1, v_reg[2:0], t1 + t2};
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (final_reg)
                begin
                    // Wait until the digest register is free.
                    if (!dig_valid_reg || out_ch.ready)
                    begin
                        dig_next       = sums;
                        dig_valid_next = 1'b1;
                        h_next         = INIT_HASH;
                        bits_next      = 64'd0;
                        padding_next   = 1'b0;
                        final_next     = 1'b0;
                        state_next     = ST_FETCH;
                    end
                end
                else
                begin
                    h_next = sums;
                    if (padding_reg)
                    begin
                        if (!first_reg)
                        begin
                            len_ok_next = 1'b1;
                        end
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_FETCH;
            end
        endcase

        if (shift_en)
        begin
            w_next = {w_reg[15][23:0], w_reg[14:0], shift_byte};
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FETCH;
            h_reg         <= INIT_HASH;
            dig_valid_reg <= 1'b0;
            bits_reg      <= 64'd0;
            pos_reg       <= 6'd0;
            rnd_reg       <= 6'd0;
            padding_reg   <= 1'b0;
            first_reg     <= 1'b0;
            len_ok_reg    <= 1'b0;
            final_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            dig_valid_reg <= dig_valid_next;
            bits_reg      <= bits_next;
            pos_reg       <= pos_next;
            rnd_reg       <= rnd_next;
            padding_reg   <= padding_next;
            first_reg     <= first_next;
            len_ok_reg    <= len_ok_next;
            final_reg     <= final_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        v_reg   <= v_next;
        dig_reg <= dig_next;
    end

    assign out_ch.valid     = dig_valid_reg;
    assign out_ch.digest_w0 = dig_reg[0];
    assign out_ch.digest_w1 = dig_reg[1];
    assign out_ch.digest_w2 = dig_reg[2];
    assign out_ch.digest_w3 = dig_reg[3];
    assign out_ch.digest_w4 = dig_reg[4];
    assign out_ch.digest_w5 = dig_reg[5];
    assign out_ch.digest_w6 = dig_reg[6];
    assign out_ch.digest_w7 = dig_reg[7];
endmodule
`default_nettype wire

/* bench/sha_tb_pkg.sv */
// Digest predictor and digest scoreboard for the SHA-256 byte-stream hasher bench.
`timescale 1ns / 1ps
`default_nettype none
package sha_tb_pkg;

    typedef logic [7:0][31:0] digest_t;

    localparam logic [7:0][31:0] IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [63:0][31:0] KTAB = {
        32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
        32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
        32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
        32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
        32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
        32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
        32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
        32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
        32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
        32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
        32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
        32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
        32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
        32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
        32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
        32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
    };

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    class digest_scoreboard;
        digest_t     hash_state;
        logic [7:0]  blk [64];
        logic [63:0] bit_count;
        digest_t     pending_digests [$];
        int          errors;

        function new();
            hash_state = IV;
            bit_count  = '0;
            errors     = 0;
            foreach (blk[i]) blk[i] = '0;
        endfunction

        // One 64-round compression of the buffered block into the hash state.
        function void compress();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] t1, t2;
            for (int t = 0; t < 16; t++)
                w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
            for (int t = 16; t < 64; t++)
                w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                       + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
            for (int i = 0; i < 8; i++) v[i] = hash_state[i];
            for (int t = 0; t < 64; t++)
            begin
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[t] + w[t];
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
        endfunction

        // Note one accepted byte transfer; a message end queues its digest.
        function void note_byte(logic [7:0] b, logic present, logic last);
            int pos;
            if (present)
            begin
                blk[bit_count[8:3]] = b;
                bit_count = bit_count + 64'd8;
                if (bit_count[8:0] == 9'd0) compress();
            end
            if (!last) return;
            pos = int'(bit_count[8:3]);
            blk[pos] = 8'h80;
            pos++;
            if (pos > 56)
            begin
                while (pos < 64) begin blk[pos] = '0; pos++; end
                compress();
                pos = 0;
            end
            while (pos < 56) begin blk[pos] = '0; pos++; end
            for (int k = 0; k < 8; k++) blk[56+k] = bit_count[8*(7-k) +: 8];
            compress();
            pending_digests.push_back(hash_state);
            hash_state = IV;
            bit_count  = '0;
        endfunction

        // Compare one digest transfer with the oldest expected digest.
        function void check_digest(digest_t got);
            digest_t want;
            if (pending_digests.size() == 0)
            begin
                $display("%0t: unexpected digest %h", $time, got);
                errors++;
                return;
            end
            want = pending_digests.pop_front();
            for (int i = 0; i < 8; i++)
                if (want[i] !== got[i])
                begin
                    $display("%0t: digest_w%0d expected %h actual %h",
                             $time, i, want[i], got[i]);
                    errors++;
                end
        endfunction
    endclass

endpackage
`default_nettype wire

/* bench/tb_top.sv */
// Top module of the SHA-256 byte-stream hasher bench.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import sha_tb_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;
    bit   idle_free;
    int   quiet_cycles;
    digest_scoreboard board;

    sha_in_if  in_ch ();
    sha_out_if out_ch ();

    sha256_byte_stream_hasher dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

    // Clock with 20 ns period.
    always
    begin
        clk = 1'b0; #10;
        clk = 1'b1; #10;
    end

    // Send one byte transfer, with a random gap before it unless idling is off.
    task automatic send_byte(input logic [7:0] b, input logic present, input logic last);
        while (!idle_free && $urandom_range(99) < 25)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.msg_byte       <= b;
        in_ch.byte_present   <= present;
        in_ch.end_of_message <= last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        board.note_byte(b, present, last);
    endtask

    // Send a message of random bytes, absent ones added if noisy, ending on its last byte or an absent item.
    task automatic send_message(input int len, input bit absent_end, input bit noisy);
        for (int i = 0; i < len; i++)
        begin
            if (noisy && $urandom_range(9) == 0)
                send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
            send_byte(8'($urandom_range(255)), 1'b1, !absent_end && i == len - 1);
        end
        if (absent_end || len == 0) send_byte(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    // Result side: random back-pressure and digest checking.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                board.check_digest({out_ch.digest_w7, out_ch.digest_w6, out_ch.digest_w5,
                                    out_ch.digest_w4, out_ch.digest_w3, out_ch.digest_w2,
                                    out_ch.digest_w1, out_ch.digest_w0});
            out_ch.ready <= idle_free || ($urandom_range(99) >= 25);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("sha256_byte_stream_hasher test failed");
            $finish;
        end
    end

    initial
    begin
        int n;
        board        = new();
        rst_n        = 1'b0;
        idle_free    = 1'b0;
        quiet_cycles = 0;
        in_ch.valid  = 1'b0;
        in_ch.msg_byte = '0;
        in_ch.byte_present = 1'b0;
        in_ch.end_of_message = 1'b0;
        out_ch.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, absent byte without end, byte extremes.
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hff, 1'b0, 1'b0);
        send_byte(8'hff, 1'b1, 1'b1);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h55, 1'b0, 1'b0);
        send_byte(8'haa, 1'b1, 1'b1);
        send_byte(8'h61, 1'b1, 1'b0);
        send_byte(8'h62, 1'b1, 1'b0);
        send_byte(8'h63, 1'b0, 1'b1);

        // Pause until every digest has come.
        while (board.pending_digests.size() != 0)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end

        // Padding boundaries: 55, 56, 63, 64 bytes, then a long run; idling is off from the 63-byte message on.
        send_message(55, 1'b0, 1'b0);
        send_message(56, 1'b1, 1'b0);
        idle_free = 1'b1;
        send_message(63, 1'b0, 1'b0);
        send_message(64, 1'b0, 1'b0);
        send_message(120, 1'b0, 1'b1);
        idle_free = 1'b0;

        // Random messages, mostly short.
        n = 0;
        while (n < 700)
        begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(20);
            send_message(len, $urandom_range(3) == 0, 1'b1);
            n += len + 1;
        end
        in_ch.valid <= 1'b0;

        while (board.pending_digests.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (board.errors == 0)
            $display("sha256_byte_stream_hasher test passed");
        else
            $display("sha256_byte_stream_hasher test failed");
        $finish;
    end
endmodule
`default_nettype wire
